### rtl/core/fletcher64_checksum_with_skip_macros.svh
// assertion helpers for the rtl
`ifndef FLETCHER64_CHECKSUM_WITH_SKIP_MACROS_SVH
`define FLETCHER64_CHECKSUM_WITH_SKIP_MACROS_SVH

// same-cycle implication
`define F64CS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define F64CS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/f64cs_pkg.sv
package f64cs_pkg;

    localparam int WORD_W      = 32;
    localparam int CSUM_W      = 2 * WORD_W;
    localparam int OFFSET_W    = 20;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = OFFSET_W;

    typedef logic [WORD_W-1:0]      t_word;
    typedef logic [CSUM_W-1:0]      t_csum;
    typedef logic [OFFSET_W-1:0]    t_offset;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    typedef logic [CFG_DATA_W-1:0]  t_cfg_data;

    localparam t_cfg_index CFG_CHECKSUM_WORD_OFFSET = t_cfg_index'(0);
    localparam t_cfg_index CFG_INSERT_MODE          = t_cfg_index'(1);

    typedef struct packed {
        logic step;
        logic last;
    } t_step;

endpackage

### rtl/core/f64cs_if.sv
interface f64cs_word_if import f64cs_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word data_word;
    logic  last_word;

    modport source (output valid, output data_word, output last_word, input ready);
    modport sink   (input valid, input data_word, input last_word, output ready);
endinterface

interface f64cs_result_if import f64cs_pkg::*; ();
    logic  valid;
    logic  ready;
    t_csum checksum_value;
    logic  checksum_ok;

    modport source (output valid, output checksum_value, output checksum_ok, input ready);
    modport sink   (input valid, input checksum_value, input checksum_ok, output ready);
endinterface

interface f64cs_cfg_if import f64cs_pkg::*; ();
    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_cfg_data  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/f64cs_accum.sv
module f64cs_accum import f64cs_pkg::*; #(
    parameter int POSITION_WIDTH = 20
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_step   i_step,
    input  t_word   i_word,
    input  t_offset i_offset,
    output t_csum   o_csum,
    output t_csum   o_stored
);

    logic [POSITION_WIDTH+OFFSET_W-1:0] w_offset_ext;
    logic [POSITION_WIDTH-1:0]          w_first_slot;
    logic [POSITION_WIDTH-1:0]          w_second_slot;
    logic                               w_hit_first;
    logic                               w_hit_second;

    t_word                     r_low,    n_low;
    t_word                     r_high,   n_high;
    logic [POSITION_WIDTH-1:0] r_pos,    n_pos;
    t_csum                     r_stored, n_stored;

    // offset taken modulo the position range
    assign w_offset_ext  = {{POSITION_WIDTH{1'b0}}, i_offset};
    assign w_first_slot  = w_offset_ext[POSITION_WIDTH-1:0];
    assign w_second_slot = w_first_slot + {{(POSITION_WIDTH-1){1'b0}}, 1'b1};
    assign w_hit_first   = (r_pos == w_first_slot);
    assign w_hit_second  = !w_hit_first && (r_pos == w_second_slot);

    always_comb begin
        n_stored = r_stored;
        n_low    = r_low;
        if (w_hit_first) begin
            n_stored[WORD_W-1:0] = i_word;
        end else if (w_hit_second) begin
            n_stored[CSUM_W-1:WORD_W] = i_word;
        end else begin
            n_low = r_low + i_word;
        end
        n_high = r_high + n_low;
        n_pos  = r_pos + {{(POSITION_WIDTH-1){1'b0}}, 1'b1};
    end

    assign o_csum   = {n_high, n_low};
    assign o_stored = n_stored;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low    <= '0;
            r_high   <= '0;
            r_pos    <= '0;
            r_stored <= '0;
        end else if (i_step.step) begin
            if (i_step.last) begin
                r_low    <= '0;
                r_high   <= '0;
                r_pos    <= '0;
                r_stored <= '0;
            end else begin
                r_low    <= n_low;
                r_high   <= n_high;
                r_pos    <= n_pos;
                r_stored <= n_stored;
            end
        end
    end

endmodule

### rtl/core/fletcher64_checksum_with_skip.sv
// Fletcher-64-style checksum (sums modulo 2^32) over a word stream, with a skipped checksum slot.
// i_data: one 32-bit word per beat, last_word marks the end of the range.
// o_result: one beat per range, the checksum {high sum, low sum} and a
// match flag (always 1 in insert mode, else checksum == stored words).
// i_cfg: register writes, index 0 the checksum word offset, index 1 the
// insert mode; always ready, write only while the block is idle.
// Throughput: one word per cycle while no last word waits on a stalled result,
// set by the single accumulate stage (two 32-bit adds per word).
// The last word's beat passes the input register, then the result register,
// on its way to the result beat.
// Reset clears the sums, the word position, the stored checksum and the
// registers (offset 0, verify mode).
// A stalled receiver holds the result; words keep flowing until a second
// last word reaches the accumulate stage, which then waits and drops
// i_data.ready until the result beat is taken.
`include "fletcher64_checksum_with_skip_macros.svh"

module fletcher64_checksum_with_skip import f64cs_pkg::*; #(
    parameter int POSITION_WIDTH = 20
) (
    input logic             i_clk,
    input logic             i_rst_n,
    f64cs_word_if.sink      i_data,
    f64cs_result_if.source  o_result,
    f64cs_cfg_if.sink       i_cfg
);

    t_offset r_offset;
    logic    r_insert;

    logic    r_s1_valid;
    logic    r_s1_last;
    t_word   r_s1_word;

    logic    r_out_valid;
    t_csum   r_out_csum;
    t_csum   r_out_stored;
    logic    r_out_insert;

    logic    w_advance;
    logic    w_in_ready;
    t_step   w_step;
    t_csum   w_csum;
    t_csum   w_stored;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_insert <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CHECKSUM_WORD_OFFSET: r_offset <= i_cfg.data[OFFSET_W-1:0];
                CFG_INSERT_MODE:          r_insert <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // input register
    assign w_advance  = r_s1_valid && (!r_s1_last || !r_out_valid || o_result.ready);
    assign w_in_ready = !r_s1_valid || w_advance;
    assign i_data.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_s1_valid <= i_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_data.valid) begin
            r_s1_last <= i_data.last_word;
            r_s1_word <= i_data.data_word;
        end
    end

    // accumulate stage
    assign w_step.step = w_advance;
    assign w_step.last = r_s1_last;

    f64cs_accum #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_word   (r_s1_word),
        .i_offset (r_offset),
        .o_csum   (w_csum),
        .o_stored (w_stored)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_last) begin
            r_out_csum   <= w_csum;
            r_out_stored <= w_stored;
            r_out_insert <= r_insert;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.checksum_value = r_out_csum;
    assign o_result.checksum_ok    = r_out_insert || (r_out_csum == r_out_stored);

    `F64CS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !i_data.ready,
        r_s1_valid && r_s1_last && r_out_valid && !o_result.ready,
        "input stalled without a blocked last beat")
    `F64CS_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, w_advance && r_s1_last,
        r_out_valid, "last beat did not produce a result")
    `F64CS_ASSERT_NEXT(a_result_held, i_clk, i_rst_n,
        !(w_advance && r_s1_last) && r_out_valid && !o_result.ready,
        r_out_valid && $stable(r_out_csum), "pending result disturbed")

endmodule
